@@ hdl/spq_pkg.sv @@
// Package for the stable priority queue: request/response word types,
// request and status codes, and sequencer states. No dependencies.
package spq_pkg;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SERVE  = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request word
  typedef struct packed {
    logic        req_type;
    logic [15:0] entry_tag;
    logic [2:0]  entry_priority;
  } req_word_t;

  // Response word
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_tag;
    logic [2:0]  served_priority;
    logic [4:0]  occupancy;
  } rsp_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_LOOK,
    SQ_CMP,
    SQ_SERVE,
    SQ_DONE
  } sq_state_t;

endpackage

@@ hdl/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/spq_core.sv @@
// Sequencer and shared priority compare for the stable priority queue.
// Entries sit in a circular buffer kept in serving order. Uses spq_pkg, spq_ram.
module spq_core #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_take,
  input  spq_pkg::req_word_t req,
  output logic              core_idle,
  input  logic              res_ready,
  output logic              res_valid,
  output spq_pkg::rsp_word_t res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = TAG_BITS + PRIORITY_BITS;

  spq_pkg::sq_state_t state, state_next;

  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            head, head_next;
  logic [CW-1:0]            idx, idx_next;
  logic [TAG_BITS-1:0]      new_tag, new_tag_next;
  logic [PRIORITY_BITS-1:0] new_prio, new_prio_next;
  spq_pkg::rsp_word_t       res_next;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [DW-1:0]            ram_rdata;

  logic [TAG_BITS-1:0]      rd_tag;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                     rd_later;
  logic [31:0]              in_tag32;
  logic [7:0]               in_prio8;
  logic [31:0]              rd_tag32;
  logic [7:0]               rd_prio8;

  // Logical position k from the head to a RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Entry count to the 5-bit occupancy field
  function automatic logic [4:0] occ(input logic [CW-1:0] c);
    logic [8:0] w;
    w = 9'(c);
    return w[4:0];
  endfunction

  spq_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Field fitting between port widths and stored widths
  assign rd_tag   = ram_rdata[DW-1:PRIORITY_BITS];
  assign rd_prio  = ram_rdata[PRIORITY_BITS-1:0];
  assign in_tag32 = 32'(req.entry_tag);
  assign in_prio8 = 8'(req.entry_priority);
  assign rd_tag32 = 32'(rd_tag);
  assign rd_prio8 = 8'(rd_prio);

  // Shared compare: stored entry ranks after the new one
  assign rd_later = rd_prio > new_prio;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::SQ_IDLE: begin
        if (req_take) begin
          if (req.req_type == spq_pkg::REQ_SERVE) begin
            state_next = (count == '0) ? spq_pkg::SQ_DONE : spq_pkg::SQ_SERVE;
          end else begin
            state_next = (count == CW'(QUEUE_DEPTH)) ? spq_pkg::SQ_DONE : spq_pkg::SQ_LOOK;
          end
        end
      end
      spq_pkg::SQ_LOOK:  state_next = (idx == '0) ? spq_pkg::SQ_DONE : spq_pkg::SQ_CMP;
      spq_pkg::SQ_CMP:   state_next = rd_later ? spq_pkg::SQ_LOOK : spq_pkg::SQ_DONE;
      spq_pkg::SQ_SERVE: state_next = spq_pkg::SQ_DONE;
      spq_pkg::SQ_DONE:  state_next = res_ready ? spq_pkg::SQ_IDLE : spq_pkg::SQ_DONE;
      default:           state_next = spq_pkg::SQ_IDLE;
    endcase
  end

  // Datapath control per state
  always_comb begin
    core_idle     = 1'b0;
    res_valid     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = phys(head, idx);
    ram_wdata     = {new_tag, new_prio};
    ram_raddr     = phys(head, idx - 1'b1);
    count_next    = count;
    head_next     = head;
    idx_next      = idx;
    new_tag_next  = new_tag;
    new_prio_next = new_prio;
    res_next      = res;
    case (state)
      spq_pkg::SQ_IDLE: begin
        core_idle = 1'b1;
        ram_raddr = head;
        if (req_take) begin
          new_tag_next             = in_tag32[TAG_BITS-1:0];
          new_prio_next            = in_prio8[PRIORITY_BITS-1:0];
          idx_next                 = count;
          res_next.status          = spq_pkg::ST_DONE;
          res_next.served_tag      = '0;
          res_next.served_priority = '0;
          res_next.occupancy       = occ(count);
          if (req.req_type == spq_pkg::REQ_SERVE) begin
            if (count == '0) begin
              res_next.status = spq_pkg::ST_EMPTY;
            end
          end else if (count == CW'(QUEUE_DEPTH)) begin
            res_next.status = spq_pkg::ST_FULL;
          end
        end
      end
      spq_pkg::SQ_LOOK: begin
        // Reached the head: new entry goes first
        if (idx == '0) begin
          ram_we             = 1'b1;
          count_next         = count + 1'b1;
          res_next.occupancy = occ(count + 1'b1);
        end
      end
      spq_pkg::SQ_CMP: begin
        ram_we = 1'b1;
        if (rd_later) begin
          // Move the later entry one place toward the tail
          ram_wdata = ram_rdata;
          idx_next  = idx - 1'b1;
        end else begin
          count_next         = count + 1'b1;
          res_next.occupancy = occ(count + 1'b1);
        end
      end
      spq_pkg::SQ_SERVE: begin
        // Head word is on the read port
        res_next.served_tag      = rd_tag32[15:0];
        res_next.served_priority = rd_prio8[2:0];
        res_next.occupancy       = occ(count - 1'b1);
        count_next               = count - 1'b1;
        head_next = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      spq_pkg::SQ_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::SQ_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    new_tag  <= new_tag_next;
    new_prio <= new_prio_next;
    res      <= res_next;
  end

endmodule

@@ hdl/stable_priority_queue.sv @@
// Top level of the stable priority queue: request port, sequencer core and
// response output register. Uses spq_pkg and spq_core.
//
// Bounded min-priority queue of tagged entries; equal priorities leave in
// arrival order. One request is worked at a time; req_stall is high while it
// is in progress. An insert walks from the tail toward the head: each waiting
// entry with a larger priority number is read and moved one place toward the
// tail through the RAM, with one priority compare per step, until a smaller or
// equal entry or the head is reached and the new entry is written. A response
// that cannot leave the output register holds the core in its done state until
// the register frees. Responses go through an output register, so the next
// request can be taken while a response waits.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  spq_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output spq_pkg::rsp_word_t rsp
);

  logic               core_idle;
  logic               res_valid;
  logic               res_ready;
  spq_pkg::rsp_word_t res;

  // Request taken only while the core is idle
  assign req_stall = !core_idle;
  assign res_ready = !rsp_valid || !rsp_stall;

  spq_core #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TAG_BITS      (TAG_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_take  (req_valid && core_idle),
    .req       (req),
    .core_idle (core_idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule
